@@ hw/rtl/kmp_pkg.sv @@
// shared constants, types and store request structs for the k-transaction profit core
// no dependencies; imported by every module of the block
package kmp_pkg;

  localparam int MAX_K      = 16;
  localparam int PRICE_BITS = 16;

  localparam int PRICE_W  = 16;
  localparam int CFG_W    = 5;
  localparam int PROFIT_W = 40;
  localparam int FREE_W   = 41;
  localparam int HOLD_W   = 42;
  localparam int ACC_W    = 44;
  localparam int LVL_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CMP_W    = ((LVL_W > CFG_W) ? LVL_W : CFG_W) + 1;

  localparam logic [PRICE_W-1:0]       PRICE_MASK = PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);
  localparam logic [PROFIT_W-1:0]      PROFIT_MAX = {PROFIT_W{1'b1}};
  localparam logic signed [HOLD_W-1:0] HOLD_MIN   = {1'b1, {(HOLD_W-1){1'b0}}};
  localparam logic [CFG_W-1:0]         K_RESET    = CFG_W'(2);
  localparam logic [LVL_W-1:0]         LVL_LAST   = LVL_W'(MAX_K - 1);

  typedef logic [LVL_W-1:0] lvl_t;

  typedef struct packed {
    logic                     en;
    lvl_t                     addr;
    logic signed [HOLD_W-1:0] hold;
    logic [FREE_W-1:0]        free;
  } kmp_wr_t;

  typedef struct packed {
    logic en;
    lvl_t addr;
  } kmp_rd_t;

endpackage

@@ hw/rtl/k_transaction_max_profit_core.sv @@
// top level: request control, level sequencer, result register and config register
// instantiates kmp_store and kmp_update; uses kmp_pkg
//
//   channel  dir     ports                                               handshake
//   in       input   in_price, in_last_price                             in_valid / in_stall
//   out      output  out_best_profit, out_sequence_done, out_saturated   out_valid / out_stall
//   cfg      input   cfg_data                                            cfg_we
//
// a request is accepted, then gets one store
// read-modify-write per level through the single write port
// a result held back by out_stall waits in ST_OUT until the output register is free
// a new request is taken while the previous result still waits on out_stall
// after reset the levels read as cleared; no clearing pass is run
module k_transaction_max_profit_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kmp_pkg::PRICE_W-1:0]     in_price,
  input  logic                            in_last_price,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kmp_pkg::PROFIT_W-1:0]    out_best_profit,
  output logic                            out_sequence_done,
  output logic                            out_saturated,
  input  logic                            cfg_we,
  input  logic [kmp_pkg::CFG_W-1:0]       cfg_data
);
  import kmp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  lvl_t                 lvl_r, lvl_nxt;
  logic [PRICE_W-1:0]   price_r, price_nxt;
  logic                 last_r, last_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 item_fresh_r, item_fresh_nxt;
  logic [CFG_W-1:0]     k_r, k_nxt;
  logic [FREE_W-1:0]    prev_free_r, prev_free_nxt;
  logic [PROFIT_W-1:0]  best_r, best_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PROFIT_W-1:0]  out_best_r, out_best_nxt;
  logic                 out_done_r, out_done_nxt;
  logic                 out_sat_r, out_sat_nxt;

  kmp_wr_t                  wr;
  kmp_rd_t                  rd;
  logic signed [HOLD_W-1:0] rd_hold;
  logic [FREE_W-1:0]        rd_free;
  logic signed [HOLD_W-1:0] hold_new;
  logic [FREE_W-1:0]        free_new;
  logic [FREE_W-1:0]        upd_prev;
  logic                     accept;
  logic                     level_last;
  logic                     level_used;
  logic                     out_free;
  logic [PROFIT_W-1:0]      best_cand;

  kmp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_hold (rd_hold),
    .rd_free (rd_free)
  );

  kmp_update u_update (
    .hold_old  (rd_hold),
    .free_old  (rd_free),
    .fresh     (item_fresh_r),
    .prev_free (upd_prev),
    .price     (price_r),
    .hold_new  (hold_new),
    .free_new  (free_new)
  );

  assign in_stall          = (state_r != ST_IDLE);
  assign accept            = in_valid && !in_stall;
  assign level_last        = (lvl_r == LVL_LAST);
  assign level_used        = (CMP_W'(lvl_r) < CMP_W'(k_r));
  assign out_free          = !out_valid_r || !out_stall;
  assign upd_prev          = (lvl_r == '0) ? '0 : prev_free_r;
  assign out_valid         = out_valid_r;
  assign out_best_profit   = out_best_r;
  assign out_sequence_done = out_done_r;
  assign out_saturated     = out_sat_r;

  always_comb begin
    best_cand = best_r;
    if (level_used && (free_new > FREE_W'(best_r))) begin
      best_cand = free_new[PROFIT_W-1:0];
    end
  end

  always_comb begin
    wr.en   = (state_r == ST_RUN);
    wr.addr = lvl_r;
    wr.hold = hold_new;
    wr.free = free_new;
    rd.en   = accept || ((state_r == ST_RUN) && !level_last);
    rd.addr = accept ? lvl_t'(0) : lvl_r + lvl_t'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    price_nxt      = price_r;
    last_nxt       = last_r;
    fresh_nxt      = fresh_r;
    item_fresh_nxt = item_fresh_r;
    k_nxt          = cfg_we ? cfg_data : k_r;
    prev_free_nxt  = prev_free_r;
    best_nxt       = best_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_best_nxt   = out_best_r;
    out_done_nxt   = out_done_r;
    out_sat_nxt    = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt      = ST_RUN;
          lvl_nxt        = '0;
          price_nxt      = in_price & PRICE_MASK;
          last_nxt       = in_last_price;
          item_fresh_nxt = fresh_r;
          fresh_nxt      = in_last_price;
          best_nxt       = '0;
        end
      end
      ST_RUN: begin
        prev_free_nxt = free_new;
        best_nxt      = best_cand;
        if (!level_last) begin
          lvl_nxt = lvl_r + lvl_t'(1);
        end else if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_best_nxt  = best_cand;
          out_done_nxt  = last_r;
          out_sat_nxt   = (best_cand == PROFIT_MAX);
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_best_nxt  = best_r;
          out_done_nxt  = last_r;
          out_sat_nxt   = (best_r == PROFIT_MAX);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      fresh_r     <= 1'b1;
      k_r         <= K_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      fresh_r     <= fresh_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r      <= price_nxt;
    last_r       <= last_nxt;
    item_fresh_r <= item_fresh_nxt;
    prev_free_r  <= prev_free_nxt;
    best_r       <= best_nxt;
    out_best_r   <= out_best_nxt;
    out_done_r   <= out_done_nxt;
    out_sat_r    <= out_sat_nxt;
  end

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (lvl_r == '0))
    else $error("accepted request did not start at level zero");

  a_level_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !level_last
      |=> (state_r == ST_RUN) && (lvl_r == $past(lvl_r) + lvl_t'(1)))
    else $error("level sequencer skipped a level");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturated == (out_best_profit == PROFIT_MAX)))
    else $error("saturated flag disagrees with profit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fresh_r) && $past(rst_n) |-> $past(accept && in_last_price))
    else $error("level clear armed without a final price");
`endif

endmodule

@@ hw/rtl/kmp_store.sv @@
// per-level state memories: holding and free best values, one entry per level
// one write and one registered read per cycle; uses kmp_pkg
module kmp_store (
  input  logic                              clk,
  input  kmp_pkg::kmp_wr_t                  wr,
  input  kmp_pkg::kmp_rd_t                  rd,
  output logic signed [kmp_pkg::HOLD_W-1:0] rd_hold,
  output logic [kmp_pkg::FREE_W-1:0]        rd_free
);
  import kmp_pkg::*;

  logic signed [HOLD_W-1:0] hold_mem [MAX_K];
  logic [FREE_W-1:0]        free_mem [MAX_K];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      hold_mem[wr.addr] <= wr.hold;
      free_mem[wr.addr] <= wr.free;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_hold <= hold_mem[rd.addr];
      rd_free <= free_mem[rd.addr];
    end
  end

endmodule

@@ hw/rtl/kmp_update.sv @@
// one level update: best buy into holding, best sell into free, with saturation
// combinational; uses kmp_pkg
module kmp_update (
  input  logic signed [kmp_pkg::HOLD_W-1:0] hold_old,
  input  logic [kmp_pkg::FREE_W-1:0]        free_old,
  input  logic                              fresh,
  input  logic [kmp_pkg::FREE_W-1:0]        prev_free,
  input  logic [kmp_pkg::PRICE_W-1:0]       price,
  output logic signed [kmp_pkg::HOLD_W-1:0] hold_new,
  output logic [kmp_pkg::FREE_W-1:0]        free_new
);
  import kmp_pkg::*;

  logic signed [ACC_W-1:0] p_e;
  logic signed [ACC_W-1:0] hold_cur;
  logic signed [ACC_W-1:0] free_cur;
  logic signed [ACC_W-1:0] prev_e;
  logic signed [ACC_W-1:0] buy;
  logic signed [ACC_W-1:0] hold_n;
  logic signed [ACC_W-1:0] sell;
  logic signed [ACC_W-1:0] free_n;
  logic signed [ACC_W-1:0] pmax_e;

  always_comb begin
    p_e      = signed'({{(ACC_W-PRICE_W){1'b0}}, price});
    prev_e   = signed'({{(ACC_W-FREE_W){1'b0}}, prev_free});
    pmax_e   = signed'({{(ACC_W-PROFIT_W){1'b0}}, PROFIT_MAX});
    // first item after a completed sequence sees cleared levels
    if (fresh) begin
      hold_cur = signed'({{(ACC_W-HOLD_W){HOLD_MIN[HOLD_W-1]}}, HOLD_MIN});
      free_cur = '0;
    end else begin
      hold_cur = signed'({{(ACC_W-HOLD_W){hold_old[HOLD_W-1]}}, hold_old});
      free_cur = signed'({{(ACC_W-FREE_W){1'b0}}, free_old});
    end
    buy    = prev_e - p_e;
    hold_n = (buy > hold_cur) ? buy : hold_cur;
    sell   = hold_n + p_e;
    free_n = (sell > free_cur) ? sell : free_cur;
    if (free_n > pmax_e) begin
      free_n = pmax_e;
    end
    hold_new = hold_n[HOLD_W-1:0];
    free_new = free_n[FREE_W-1:0];
  end

endmodule
